### sv/bounded_deque_with_value_removal_defines.svh
// assertion macros shared by the deque rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BOUNDED_DEQUE_WITH_VALUE_REMOVAL_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_VALUE_REMOVAL_DEFINES_SVH

// same-cycle implication
`define BDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bdq_pkg.sv
// shared types and constants for the bounded deque
// no dependencies
package bdq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int VALUE_W     = 32;
  localparam int CNT_W       = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_READ_FIRST = 3'd6,
    OP_READ_LAST  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CMP_RD,
    S_CMP_WR,
    S_RD_ISSUE,
    S_RD_EMIT,
    S_RESP_OK,
    S_RESP_NF
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    clear;
    logic    init_search;
    logic    init_read;
    logic    mem_rd;
    logic    rd_next;
    logic    mem_wr;
    logic    pos_inc;
    logic    occ_dec;
    logic    out_load;
    logic    out_data;
    logic    out_last;
    status_e out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic cnt_zero;
    logic match;
    logic srch_last;
    logic next_last;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

### sv/bdq_in_if.sv
// request channel of the deque: operation, value and count
// depends on bdq_pkg
interface bdq_in_if import bdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  op_e                       operation;
  logic signed [VALUE_W-1:0] value;
  logic [CNT_W-1:0]          count;

  modport source (output valid, output operation, output value, output count, input ready);
  modport sink   (input valid, input operation, input value, input count, output ready);
endinterface

### sv/bdq_out_if.sv
// result channel of the deque: entry, last marker and status
// depends on bdq_pkg
interface bdq_out_if import bdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] elem_value;
  logic                      last;
  status_e                   status;

  modport source (output valid, output elem_value, output last, output status, input ready);
  modport sink   (input valid, input elem_value, input last, input status, output ready);
endinterface

### sv/bounded_deque_with_value_removal.sv
// Bounded double-ended queue of signed 32-bit words, DEPTH entries in a circular ram.
// req_i carries one operation per item: push front/back, pop front/back, clear,
// remove first entry equal to value, read first or last count entries.
// rsp_o returns results through an output register: one per item, except reads,
// which return one per entry streamed in queue order, last set on the final one.
// Steps, with the ram read registered:
//   push, pop, clear and empty/full cases: result registered at accept
//   remove: a ram read and a compare per entry searched up to the match, then a read
//   and a write per entry closed up behind it, then the result is presented
//   read: one ram read and one output load per result
// One item is in work at a time; req_i.ready is high only when idle and the output
// register is free or being taken.
// Reset empties the queue (head and occupancy to zero); the ram is not cleared.
// A stalled receiver holds the current result and the block waits with it.
// Depends on bdq_pkg, bdq_in_if, bdq_out_if, bdq_ctrl, bdq_dp, bdq_ram.
module bounded_deque_with_value_removal import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  bdq_in_if.sink  req_i,
  bdq_out_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_op_i   (req_i.operation),
    .req_ready_o(req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_op_i    (req_i.operation),
    .req_value_i (req_i.value),
    .req_count_i (req_i.count),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_elem_o  (rsp_o.elem_value),
    .rsp_last_o  (rsp_o.last),
    .rsp_status_o(rsp_o.status)
  );

endmodule

### sv/bdq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bdq_ctrl.sv
// sequencer of the deque: decodes requests and steps search, compaction and reads
// depends on bdq_pkg
module bdq_ctrl import bdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  op_e  req_op_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept      = req_ready_o && req_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_op_i)
            OP_REMOVE: begin
              if (!sts_i.empty) state_d = S_SRCH_RD;
            end
            OP_READ_FIRST, OP_READ_LAST: begin
              if (!sts_i.empty && !sts_i.cnt_zero) state_d = S_RD_ISSUE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD:  state_d = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (sts_i.match) begin
          state_d = sts_i.srch_last ? S_RESP_OK : S_CMP_RD;
        end else begin
          state_d = sts_i.srch_last ? S_RESP_NF : S_SRCH_RD;
        end
      end
      S_CMP_RD:   state_d = S_CMP_WR;
      S_CMP_WR:   state_d = sts_i.next_last ? S_RESP_OK : S_CMP_RD;
      S_RD_ISSUE: state_d = S_RD_EMIT;
      S_RD_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.rd_last ? S_IDLE : S_RD_ISSUE;
      end
      S_RESP_OK, S_RESP_NF: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_last   = 1'b1;
    cmd_o.out_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_op_i)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.push_front = (req_op_i == OP_PUSH_FRONT);
                cmd_o.push_back  = (req_op_i == OP_PUSH_BACK);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.empty) begin
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.pop_front = (req_op_i == OP_POP_FRONT);
                cmd_o.occ_dec   = (req_op_i == OP_POP_BACK);
              end
            end
            OP_CLEAR: begin
              cmd_o.out_load = 1'b1;
              cmd_o.clear    = 1'b1;
            end
            OP_REMOVE: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.init_search = 1'b1;
              end
            end
            OP_READ_FIRST, OP_READ_LAST: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else if (sts_i.cnt_zero) begin
                cmd_o.out_load = 1'b1;
              end else begin
                cmd_o.init_read = 1'b1;
              end
            end
            default: cmd_o.out_load = 1'b0;
          endcase
        end
      end
      S_SRCH_RD: cmd_o.mem_rd = 1'b1;
      S_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.occ_dec = sts_i.srch_last;
        end else begin
          cmd_o.pos_inc = !sts_i.srch_last;
        end
      end
      S_CMP_RD: begin
        cmd_o.mem_rd  = 1'b1;
        cmd_o.rd_next = 1'b1;
      end
      S_CMP_WR: begin
        // close up: entry behind moves into the current slot
        cmd_o.mem_wr  = 1'b1;
        cmd_o.pos_inc = 1'b1;
        cmd_o.occ_dec = sts_i.next_last;
      end
      S_RD_ISSUE: cmd_o.mem_rd = 1'b1;
      S_RD_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_data = 1'b1;
          cmd_o.out_last = sts_i.rd_last;
          cmd_o.pos_inc  = !sts_i.rd_last;
        end
      end
      S_RESP_OK: cmd_o.out_load = sts_i.out_free;
      S_RESP_NF: begin
        cmd_o.out_load   = sts_i.out_free;
        cmd_o.out_status = ST_NOT_FOUND;
      end
      default: cmd_o.out_load = 1'b0;
    endcase
  end

endmodule

### sv/bdq_dp.sv
// datapath of the deque: head and occupancy, position counters, entry ram, result register
// depends on bdq_pkg, bdq_ram and the assertion macros
`include "bounded_deque_with_value_removal_defines.svh"

module bdq_dp import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  op_e                       req_op_i,
  input  logic signed [VALUE_W-1:0] req_value_i,
  input  logic [CNT_W-1:0]          req_count_i,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output logic signed [VALUE_W-1:0] rsp_elem_o,
  output logic                      rsp_last_o,
  output status_e                   rsp_status_o
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int NW    = (OCC_W > CNT_W) ? OCC_W : CNT_W;

  logic [IDX_W-1:0]   head_q, head_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [OCC_W-1:0]   pos_q, end_q;
  logic [VALUE_W-1:0] val_q;

  logic               out_vld_q;
  logic [VALUE_W-1:0] out_elem_q;
  logic               out_last_q;
  status_e            out_status_q;

  logic [IDX_W-1:0]   head_m1, head_p1;
  logic [OCC_W:0]     pos_p1_w, pos_p2_w;
  logic [IDX_W-1:0]   raddr, waddr;
  logic [VALUE_W-1:0] wdata, rdata;
  logic               we;
  logic [NW-1:0]      cnt_n, occ_n, n_min, n_sel;
  logic [OCC_W-1:0]   n_len, rd_start, rd_end;

  // circular slot of a queue position, position + head stays below twice the depth
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [OCC_W:0]   pos);
    logic [OCC_W+1:0] sum;
    sum = (OCC_W+2)'(head) + (OCC_W+2)'(pos);
    if (sum >= (OCC_W+2)'(DEPTH)) sum = sum - (OCC_W+2)'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  assign head_m1  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
  assign head_p1  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign pos_p1_w = {1'b0, pos_q} + 1'b1;
  assign pos_p2_w = {1'b0, pos_q} + 2'd2;

  // read length saturates at occupancy and at the result limit
  assign cnt_n    = NW'(req_count_i);
  assign occ_n    = NW'(occ_q);
  assign n_min    = (cnt_n < occ_n) ? cnt_n : occ_n;
  assign n_sel    = (n_min > NW'(MAX_RESULTS)) ? NW'(MAX_RESULTS) : n_min;
  assign n_len    = n_sel[OCC_W-1:0];
  assign rd_start = (req_op_i == OP_READ_FIRST) ? '0 : occ_q - n_len;
  assign rd_end   = (req_op_i == OP_READ_FIRST) ? n_len : occ_q;

  // ram ports
  assign raddr = cmd_i.rd_next ? slot_of(head_q, pos_p1_w) : slot_of(head_q, {1'b0, pos_q});
  assign we    = cmd_i.push_front || cmd_i.push_back || cmd_i.mem_wr;
  assign wdata = cmd_i.mem_wr ? rdata : req_value_i;

  always_comb begin
    priority if (cmd_i.push_front) begin
      waddr = head_m1;
    end else if (cmd_i.push_back) begin
      waddr = slot_of(head_q, {1'b0, occ_q});
    end else begin
      waddr = slot_of(head_q, {1'b0, pos_q});
    end
  end

  bdq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.mem_rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // head and occupancy
  always_comb begin
    head_d = head_q;
    occ_d  = occ_q;
    priority if (cmd_i.clear) begin
      head_d = '0;
      occ_d  = '0;
    end else if (cmd_i.push_front) begin
      head_d = head_m1;
      occ_d  = occ_q + 1'b1;
    end else if (cmd_i.push_back) begin
      occ_d  = occ_q + 1'b1;
    end else if (cmd_i.pop_front) begin
      head_d = head_p1;
      occ_d  = occ_q - 1'b1;
    end else if (cmd_i.occ_dec) begin
      occ_d  = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      occ_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      head_q <= head_d;
      occ_q  <= occ_d;
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_search) begin
      pos_q <= '0;
      val_q <= req_value_i;
    end else if (cmd_i.init_read) begin
      pos_q <= rd_start;
      end_q <= rd_end;
    end else if (cmd_i.pos_inc) begin
      pos_q <= pos_p1_w[OCC_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_elem_q   <= cmd_i.out_data ? rdata : '0;
      out_last_q   <= cmd_i.out_last;
      out_status_q <= cmd_i.out_status;
    end
  end

  assign sts_o.empty     = (occ_q == '0);
  assign sts_o.full      = (occ_q == OCC_W'(DEPTH));
  assign sts_o.cnt_zero  = (req_count_i == '0);
  assign sts_o.match     = (rdata == val_q);
  assign sts_o.srch_last = (pos_p1_w >= {1'b0, occ_q});
  assign sts_o.next_last = (pos_p2_w >= {1'b0, occ_q});
  assign sts_o.rd_last   = (pos_p1_w >= {1'b0, end_q});
  assign sts_o.out_free  = !out_vld_q || rsp_ready_i;

  assign rsp_valid_o  = out_vld_q;
  assign rsp_elem_o   = out_elem_q;
  assign rsp_last_o   = out_last_q;
  assign rsp_status_o = out_status_q;

  `BDQ_ASSERT_IMP(a_load_free, cmd_i.out_load, sts_o.out_free, "result overwritten while held")
  `BDQ_ASSERT_IMP(a_compact_rng, cmd_i.mem_wr, pos_p1_w < {1'b0, occ_q}, "compaction past tail")
  `BDQ_ASSERT_IMP(a_read_rng, cmd_i.mem_rd && !cmd_i.rd_next, pos_q < occ_q, "read past tail")
  `BDQ_ASSERT_NXT(a_push_grow, cmd_i.push_front || cmd_i.push_back, occ_q == $past(occ_q) + 1'b1,
    "push did not grow occupancy")

endmodule

### tb/sv/tb_bounded_deque_with_value_removal.sv
`timescale 1ns / 100ps
// testbench for the bounded deque: random and directed operations with a queue-side model
// depends on bdq_pkg, bdq_in_if, bdq_out_if and bounded_deque_with_value_removal
module tb_bounded_deque_with_value_removal;
  import bdq_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 100;

  typedef struct {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          count;
  } deque_req_t;

  typedef struct {
    logic signed [VALUE_W-1:0] elem;
    logic                      last;
    status_e                   status;
  } deque_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      tx_valid = 1'b0;
  op_e                       tx_op    = OP_PUSH_FRONT;
  logic signed [VALUE_W-1:0] tx_value = '0;
  logic [CNT_W-1:0]          tx_count = '0;
  logic                      rx_ready = 1'b0;

  bdq_in_if  req_if ();
  bdq_out_if rsp_if ();

  assign req_if.valid     = tx_valid;
  assign req_if.operation = tx_op;
  assign req_if.value     = tx_value;
  assign req_if.count     = tx_count;
  assign rsp_if.ready     = rx_ready;

  bounded_deque_with_value_removal #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  deque_req_t req_backlog[$];
  deque_rsp_t rsp_due[$];

  int  tx_idle_pct = 21;
  int  rx_idle_pct = 56;
  bit  hold_go     = 1'b0;
  int  err_count   = 0;

  // queue model
  logic signed [VALUE_W-1:0] mdl_mem [DEPTH];
  int                        mdl_head = 0;
  int                        mdl_occ  = 0;

  function automatic int slot_at(input int pos);
    return (mdl_head + pos) % DEPTH;
  endfunction

  function automatic void add_due(input logic signed [VALUE_W-1:0] e, input logic l,
                                  input status_e s);
    deque_rsp_t d;
    d.elem   = e;
    d.last   = l;
    d.status = s;
    rsp_due.push_back(d);
  endfunction

  task automatic deque_apply(input deque_req_t r);
    int i;
    int n;
    int start;
    int pos;
    bit hit;
    case (r.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (mdl_occ >= DEPTH) begin
          add_due('0, 1'b1, ST_FULL);
        end else begin
          if (r.op == OP_PUSH_FRONT) begin
            mdl_head = (mdl_head + DEPTH - 1) % DEPTH;
            mdl_mem[mdl_head] = r.value;
          end else begin
            mdl_mem[slot_at(mdl_occ)] = r.value;
          end
          mdl_occ++;
          add_due('0, 1'b1, ST_OK);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (mdl_occ == 0) begin
          add_due('0, 1'b1, ST_EMPTY);
        end else begin
          if (r.op == OP_POP_FRONT) mdl_head = (mdl_head + 1) % DEPTH;
          mdl_occ--;
          add_due('0, 1'b1, ST_OK);
        end
      end
      OP_CLEAR: begin
        mdl_head = 0;
        mdl_occ  = 0;
        add_due('0, 1'b1, ST_OK);
      end
      OP_REMOVE: begin
        if (mdl_occ == 0) begin
          add_due('0, 1'b1, ST_EMPTY);
        end else begin
          hit = 1'b0;
          pos = 0;
          for (i = 0; i < mdl_occ; i++) begin
            if (!hit && mdl_mem[slot_at(i)] == r.value) begin
              hit = 1'b1;
              pos = i;
            end
          end
          if (!hit) begin
            add_due('0, 1'b1, ST_NOT_FOUND);
          end else begin
            // entries behind the match close up toward the front
            for (i = pos; i + 1 < mdl_occ; i++) mdl_mem[slot_at(i)] = mdl_mem[slot_at(i + 1)];
            mdl_occ--;
            add_due('0, 1'b1, ST_OK);
          end
        end
      end
      default: begin
        if (mdl_occ == 0) begin
          add_due('0, 1'b1, ST_EMPTY);
        end else if (r.count == 0) begin
          add_due('0, 1'b1, ST_OK);
        end else begin
          n = (int'(r.count) < mdl_occ) ? int'(r.count) : mdl_occ;
          if (n > MAX_RESULTS) n = MAX_RESULTS;
          start = (r.op == OP_READ_FIRST) ? 0 : mdl_occ - n;
          for (i = 0; i < n; i++) add_due(mdl_mem[slot_at(start + i)], (i + 1 == n), ST_OK);
        end
      end
    endcase
  endtask

  // driver: offers items from the backlog, random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drv
    deque_req_t cur;
    deque_req_t nxt;
    if (!rst_ni) begin
      tx_valid <= 1'b0;
      tx_op    <= OP_PUSH_FRONT;
      tx_value <= '0;
      tx_count <= '0;
    end else begin
      if (tx_valid && req_if.ready) begin
        cur.op    = tx_op;
        cur.value = tx_value;
        cur.count = tx_count;
        deque_apply(cur);
      end
      if (!tx_valid || req_if.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = req_backlog.pop_front();
          tx_op    <= nxt.op;
          tx_value <= nxt.value;
          tx_count <= nxt.count;
          tx_valid <= 1'b1;
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results, drives ready, long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin : mon
    deque_rsp_t exp_rsp;
    int         hold_left;
    bit         hold_taken;
    int         quiet_cycles;
    if (!rst_ni) begin
      rx_ready     <= 1'b0;
      hold_left    = 0;
      hold_taken   = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (rsp_if.valid && rx_ready) begin
        if (rsp_due.size() == 0) begin
          $display("%0t unexpected item: elem %h last %b status %0d", $time,
                   rsp_if.elem_value, rsp_if.last, rsp_if.status);
          err_count++;
        end else begin
          exp_rsp = rsp_due.pop_front();
          if (rsp_if.elem_value !== exp_rsp.elem) begin
            $display("%0t elem_value mismatch: expected %h actual %h", $time,
                     exp_rsp.elem, rsp_if.elem_value);
            err_count++;
          end
          if (rsp_if.last !== exp_rsp.last) begin
            $display("%0t last mismatch: expected %b actual %b", $time,
                     exp_rsp.last, rsp_if.last);
            err_count++;
          end
          if (rsp_if.status !== exp_rsp.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time,
                     exp_rsp.status, rsp_if.status);
            err_count++;
          end
        end
      end

      if ((tx_valid && req_if.ready) || (rsp_if.valid && rx_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("TB_ERROR");
        $finish;
      end

      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  logic signed [VALUE_W-1:0] val_pool [8];

  task automatic add_item(input op_e op, input int v, input int c);
    deque_req_t r;
    r.op    = op;
    r.value = v;
    r.count = CNT_W'(c);
    req_backlog.push_back(r);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || tx_valid || rsp_due.size() != 0);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return val_pool[3'($urandom_range(0, 7))];
    return $urandom;
  endfunction

  function automatic int pick_count();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 31));
    return int'($urandom_range(0, 17));
  endfunction

  task automatic gen_random(input int num);
    int k;
    int pick;
    for (k = 0; k < num; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22)      add_item(OP_PUSH_BACK, pick_value(60), $urandom);
      else if (pick < 40) add_item(OP_PUSH_FRONT, pick_value(60), $urandom);
      else if (pick < 50) add_item(OP_POP_FRONT, $urandom, $urandom);
      else if (pick < 58) add_item(OP_POP_BACK, $urandom, $urandom);
      else if (pick < 72) add_item(OP_REMOVE, pick_value(75), $urandom);
      else if (pick < 84) add_item(OP_READ_FIRST, $urandom, pick_count());
      else if (pick < 96) add_item(OP_READ_LAST, $urandom, pick_count());
      else                add_item(OP_CLEAR, $urandom, $urandom);
    end
  endtask

  initial begin : stim
    int k;
    val_pool[0] = 32'sh8000_0000;
    val_pool[1] = 32'sh7fff_ffff;
    val_pool[2] = '0;
    val_pool[3] = -32'sd1;
    for (k = 4; k < 8; k++) val_pool[k] = $urandom;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_idling(21, 56);
    // empty-queue cases, then pushes at both ends
    add_item(OP_READ_FIRST, 0, 3);
    add_item(OP_REMOVE, 7, 0);
    add_item(OP_POP_FRONT, 0, 0);
    add_item(OP_POP_BACK, 0, 0);
    add_item(OP_READ_LAST, 0, 0);
    add_item(OP_PUSH_BACK, 32'sh7fff_ffff, 0);
    add_item(OP_PUSH_FRONT, 32'sh8000_0000, 31);
    add_item(OP_PUSH_BACK, 0, 0);
    add_item(OP_PUSH_BACK, -32'sd1, 0);
    add_item(OP_PUSH_FRONT, 1, 0);
    add_item(OP_PUSH_BACK, 5, 0);
    add_item(OP_PUSH_BACK, 5, 0);
    // zero-length read, reads past and within the occupancy, then a remove that finds nothing
    add_item(OP_READ_FIRST, -32'sd1, 0);
    add_item(OP_READ_FIRST, 0, 31);
    add_item(OP_READ_LAST, 0, 2);
    add_item(OP_READ_LAST, 0, 16);
    add_item(OP_REMOVE, 12345, 0);
    // duplicates: only the first one goes
    add_item(OP_REMOVE, 5, 0);
    add_item(OP_REMOVE, 32'sh8000_0000, 0);
    add_item(OP_POP_FRONT, 0, 0);
    add_item(OP_POP_BACK, 0, 0);
    add_item(OP_READ_FIRST, 0, 16);
    add_item(OP_CLEAR, 0, 0);
    add_item(OP_CLEAR, 0, 0);
    add_item(OP_READ_LAST, 0, 1);
    gen_random(20);
    wait_drained();

    set_idling(56, 21);
    gen_random(20);
    wait_drained();

    // receiver holds off while the sender keeps offering: queue fills, input stalls
    set_idling(0, 0);
    hold_go = 1'b1;
    for (k = 0; k < 20; k++) begin
      if (k % 3 == 0) add_item(OP_PUSH_FRONT, pick_value(30), $urandom);
      else            add_item(OP_PUSH_BACK, pick_value(30), $urandom);
    end
    add_item(OP_READ_LAST, 0, 16);
    add_item(OP_REMOVE, val_pool[3'($urandom_range(0, 7))], 0);
    add_item(OP_READ_FIRST, 0, 31);
    wait_drained();

    gen_random(15);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_count == 0 && rsp_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
